[rtl/bhte_pkg.sv]
// ----------------------------------------------------------------------------
// bhte_pkg
// Shared job type, pad character and symbol lookups for the text encoder.
// ----------------------------------------------------------------------------
package bhte_pkg;

	localparam logic [6:0] CH_PAD = 7'h3D;

	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [1:0]      last_idx;
		logic            last;
	} bhte_job_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] ch;
		if (nib < 4'd10) begin
			ch = 7'h30 + {3'd0, nib};
		end else begin
			ch = 7'h57 + {3'd0, nib};
		end
		return ch;
	endfunction

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] ch;
		if (v < 6'd26) begin
			ch = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			ch = 7'h47 + {1'b0, v};
		end else if (v < 6'd62) begin
			ch = {1'b0, v} - 7'h04;
		end else if (v == 6'd62) begin
			ch = 7'h2B;
		end else begin
			ch = 7'h2F;
		end
		return ch;
	endfunction

endpackage

[rtl/bhte_front.sv]
// ----------------------------------------------------------------------------
// bhte_front
// Accepts input bytes, holds the mode and leftover bits, builds a character job.
// ----------------------------------------------------------------------------
module bhte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                q_full,
	output logic                push,
	output bhte_pkg::bhte_job_t job
);
	import bhte_pkg::*;

	localparam logic [2:0] LEFT_NONE = 3'd0;
	localparam logic [2:0] LEFT_TWO  = 3'd2;
	localparam logic [2:0] LEFT_FOUR = 3'd4;

	logic       mode_q;
	logic [3:0] bits_q;
	logic [2:0] cnt_q;
	logic [3:0] bits_nxt;
	logic [2:0] cnt_nxt;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		job       = '0;
		job.last  = last_byte;
		bits_nxt  = 4'd0;
		cnt_nxt   = LEFT_NONE;
		if (!mode_q) begin
			job.chars[0] = hex_char(data_byte[7:4]);
			job.chars[1] = hex_char(data_byte[3:0]);
			job.last_idx = 2'd1;
		end else begin
			unique case (cnt_q)
				LEFT_FOUR: begin
					job.chars[0] = b64_char({bits_q, data_byte[7:6]});
					job.chars[1] = b64_char(data_byte[5:0]);
					job.last_idx = 2'd1;
				end
				LEFT_TWO: begin
					job.chars[0] = b64_char({bits_q[1:0], data_byte[7:4]});
					if (last_byte) begin
						job.chars[1] = b64_char({data_byte[3:0], 2'b00});
						job.chars[2] = CH_PAD;
						job.last_idx = 2'd2;
					end else begin
						job.last_idx = 2'd0;
						bits_nxt     = data_byte[3:0];
						cnt_nxt      = LEFT_FOUR;
					end
				end
				default: begin
					job.chars[0] = b64_char(data_byte[7:2]);
					if (last_byte) begin
						job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
						job.chars[2] = CH_PAD;
						job.chars[3] = CH_PAD;
						job.last_idx = 2'd3;
					end else begin
						job.last_idx = 2'd0;
						bits_nxt     = {2'b00, data_byte[1:0]};
						cnt_nxt      = LEFT_TWO;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bits_q <= 4'd0;
			cnt_q  <= LEFT_NONE;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (push) begin
				bits_q <= bits_nxt;
				cnt_q  <= cnt_nxt;
			end
		end
	end

endmodule

[rtl/bhte_queue.sv]
// ----------------------------------------------------------------------------
// bhte_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module bhte_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bhte_pkg::bhte_job_t push_job,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output bhte_pkg::bhte_job_t head
);
	import bhte_pkg::*;

	bhte_job_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/bhte_back.sv]
// ----------------------------------------------------------------------------
// bhte_back
// Pops jobs and sends their characters one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module bhte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  bhte_pkg::bhte_job_t q_head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          text_char,
	output logic                last_char
);
	import bhte_pkg::*;

	bhte_job_t  cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       advance;
	logic       job_done;

	assign advance   = !out_valid_q || out_ready;
	assign job_done  = !cur_valid_q || (idx_q == cur_q.last_idx);
	assign pop       = advance && job_done && q_not_empty;
	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk) begin
		if (advance && cur_valid_q) begin
			char_q <= cur_q.chars[idx_q];
			last_q <= cur_q.last && (idx_q == cur_q.last_idx);
		end
		if (pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cur_valid_q;
			if (job_done) begin
				cur_valid_q <= q_not_empty;
				idx_q       <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

[rtl/base64_or_hex_text_encoder.sv]
// ----------------------------------------------------------------------------
// base64_or_hex_text_encoder
// Byte stream to lower-case hex or padded base64 ASCII text.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------
//  in       | input     | in_valid / in_ready   | data_byte, last_byte
//  out      | output    | out_valid / out_ready | text_char, last_char
//  cfg      | input     | cfg_we                | cfg_wdata (encode_mode)
//
//  One character leaves per cycle while out_ready is high and one is pending;
//  a byte yields 1 to 4 characters (two in hex, one or two in base64, up to
//  four on the last byte). A byte enters in the cycle it is offered while the
//  two-entry job queue has room; its characters pass the queue entry, the
//  current-job and output registers. Input stalls when the queue fills: when
//  bytes outrun their characters, as with hex back to back, or output stalls.
//  Reset clears the mode to hex and drops any pending base64 bits.
// ----------------------------------------------------------------------------
module base64_or_hex_text_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] text_char,
	output logic       last_char
);
	import bhte_pkg::*;

	bhte_job_t push_job;
	bhte_job_t head_job;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_not_empty;

	bhte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	bhte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	bhte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_char   (text_char),
		.last_char   (last_char)
	);

endmodule
